>>> hw/rtl/cscan_pkg.sv
package cscan_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    localparam int CYL_W  = 16;
    localparam int SEEK_W = 18;
    localparam int SIZE_W = 17;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [SIZE_W-1:0] DISK_SIZE_RST = 17'h10000;
    localparam logic [SIZE_W-1:0] DISK_SIZE_MIN = 17'h00002;
    localparam logic [SIZE_W-1:0] DISK_SIZE_MAX = 17'h10000;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;

    localparam logic [APB_AW-3:0] REG_DISK_SIZE = '0;

    typedef struct packed {
        logic add;
        logic run_start;
        logic scan_start;
        logic emit;
        logic ret;
        logic finish;
        logic dn;
    } cscan_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic up_pick_end;
        logic have_cand;
        logic dn_last;
    } cscan_sts_t;

endpackage

>>> hw/rtl/cscan_ctrl.sv
module cscan_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_req_type,
    output logic                  s_ready,
    input  cscan_pkg::cscan_sts_t sts,
    output cscan_pkg::cscan_cmd_t cmd
);
    import cscan_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_UP   = 3'b010,
        ST_DN   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.dn         = (state_reg == ST_DN);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_RUN) begin
                        cmd.run_start  = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_UP;
                    end else begin
                        cmd.add = 1'b1;
                    end
                end
            end
            ST_UP: begin
                if (sts.scan_done && sts.out_free) begin
                    cmd.scan_start = 1'b1;
                    if (sts.up_pick_end || sts.have_cand) begin
                        cmd.emit = 1'b1;
                    end else begin
                        cmd.ret    = 1'b1;
                        state_next = ST_DN;
                    end
                end
            end
            ST_DN: begin
                if (sts.scan_done && sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.dn_last) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan_start = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/cscan_dp.sv
module cscan_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [cscan_pkg::CYL_W-1:0]     s_cylinder,
    input  logic [cscan_pkg::SIZE_W-1:0]    disk_size,
    input  cscan_pkg::cscan_cmd_t           cmd,
    output cscan_pkg::cscan_sts_t           sts,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [cscan_pkg::CYL_W-1:0]     m_cylinder_res,
    output logic [cscan_pkg::SEEK_W-1:0]    m_total_seek,
    output logic                            m_last
);
    import cscan_pkg::*;

    logic [CYL_W-1:0]        mem [MAX_REQUESTS];

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [MAX_REQUESTS-1:0] used_reg, used_next;
    logic                    end_done_reg, end_done_next;
    logic                    zero_done_reg, zero_done_next;
    logic                    issuing_reg, issuing_next;
    logic [IDX_W-1:0]        issue_idx_reg, issue_idx_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [CYL_W-1:0]        rd_data_reg;
    logic [CNT_W-1:0]        cand_cnt_reg, cand_cnt_next;
    logic [CYL_W-1:0]        best_reg, best_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [CYL_W-1:0]        head_reg, head_next;
    logic [CYL_W-1:0]        pos_reg, pos_next;
    logic [SEEK_W-1:0]       seek_reg, seek_next;
    logic                    m_valid_reg, m_valid_next;
    logic [CYL_W-1:0]        m_cyl_reg, m_cyl_next;
    logic [SEEK_W-1:0]       m_seek_reg, m_seek_next;
    logic                    m_last_reg, m_last_next;

    logic [SIZE_W-1:0]       eff_size;
    logic [SIZE_W-1:0]       end_full;
    logic [CYL_W-1:0]        end_cyl;
    logic                    add_ok;
    logic                    have_cand;
    logic                    up_pick_end;
    logic                    dn_last;
    logic                    emit_req;
    logic [CYL_W-1:0]        emit_cyl;
    logic [CYL_W-1:0]        step_dist;
    logic [SEEK_W-1:0]       seek_sum;
    logic                    last_issue;
    logic                    cand;

    // saturate disk size on use
    always_comb begin
        if (disk_size < DISK_SIZE_MIN) begin
            eff_size = DISK_SIZE_MIN;
        end else if (disk_size > DISK_SIZE_MAX) begin
            eff_size = DISK_SIZE_MAX;
        end else begin
            eff_size = disk_size;
        end
    end

    assign end_full    = eff_size - SIZE_W'(1);
    assign end_cyl     = end_full[CYL_W-1:0];
    assign add_ok      = cmd.add && (count_reg < CNT_W'(MAX_REQUESTS))
                         && ({1'b0, s_cylinder} < eff_size);
    assign have_cand   = (cand_cnt_reg != '0);
    assign up_pick_end = !end_done_reg && (!have_cand || (end_cyl <= best_reg));
    assign dn_last     = zero_done_reg ? (cand_cnt_reg == CNT_W'(1)) : !have_cand;
    assign emit_req    = cmd.dn ? zero_done_reg : !up_pick_end;

    always_comb begin
        if (cmd.dn) begin
            emit_cyl = zero_done_reg ? best_reg : '0;
        end else begin
            emit_cyl = up_pick_end ? end_cyl : best_reg;
        end
    end

    assign step_dist = (emit_cyl > pos_reg) ? (emit_cyl - pos_reg)
                                            : (pos_reg - emit_cyl);
    assign seek_sum  = seek_reg + SEEK_W'(step_dist);

    assign last_issue = (CNT_W'(issue_idx_reg) == (count_reg - CNT_W'(1)));
    assign cand       = rd_vld_reg && !used_reg[rd_idx_reg]
                        && (cmd.dn ? (rd_data_reg < head_reg) : (rd_data_reg > head_reg));

    always_comb begin
        count_next     = count_reg;
        used_next      = used_reg;
        end_done_next  = end_done_reg;
        zero_done_next = zero_done_reg;
        issuing_next   = issuing_reg;
        issue_idx_next = issue_idx_reg;
        rd_vld_next    = issuing_reg;
        rd_idx_next    = issue_idx_reg;
        cand_cnt_next  = cand_cnt_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        head_next      = head_reg;
        pos_next       = pos_reg;
        seek_next      = seek_reg;
        m_valid_next   = m_valid_reg;
        m_cyl_next     = m_cyl_reg;
        m_seek_next    = m_seek_reg;
        m_last_next    = m_last_reg;

        if (add_ok) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.finish) begin
            count_next = '0;
        end

        if (cmd.run_start) begin
            used_next      = '0;
            end_done_next  = 1'b0;
            zero_done_next = 1'b0;
            head_next      = s_cylinder;
            pos_next       = s_cylinder;
            seek_next      = '0;
        end

        // one sweep over the store per served cylinder
        if (cmd.scan_start) begin
            issuing_next   = (count_reg != '0);
            issue_idx_next = '0;
            cand_cnt_next  = '0;
        end else begin
            if (issuing_reg) begin
                if (last_issue) begin
                    issuing_next = 1'b0;
                end else begin
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                end
            end
            if (cand) begin
                cand_cnt_next = cand_cnt_reg + CNT_W'(1);
                if (!have_cand || (rd_data_reg < best_reg)) begin
                    best_next     = rd_data_reg;
                    best_idx_next = rd_idx_reg;
                end
            end
        end

        if (cmd.emit) begin
            if (emit_req) begin
                used_next[best_idx_reg] = 1'b1;
            end
            if (!cmd.dn && up_pick_end) begin
                end_done_next = 1'b1;
            end
            if (cmd.dn && !zero_done_reg) begin
                zero_done_next = 1'b1;
            end
            pos_next     = emit_cyl;
            seek_next    = seek_sum;
            m_valid_next = 1'b1;
            m_cyl_next   = emit_cyl;
            m_last_next  = cmd.dn && dn_last;
            m_seek_next  = (cmd.dn && dn_last) ? seek_sum : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // return jump to cylinder 0
        if (cmd.ret) begin
            pos_next  = '0;
            seek_next = seek_reg + SEEK_W'(end_cyl);
        end
    end

    always_ff @(posedge aclk) begin
        if (add_ok) begin
            mem[count_reg[IDX_W-1:0]] <= s_cylinder;
        end
        if (issuing_reg) begin
            rd_data_reg <= mem[issue_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            used_reg      <= '0;
            end_done_reg  <= 1'b0;
            zero_done_reg <= 1'b0;
            issuing_reg   <= 1'b0;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            cand_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            used_reg      <= used_next;
            end_done_reg  <= end_done_next;
            zero_done_reg <= zero_done_next;
            issuing_reg   <= issuing_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= rd_vld_next;
            cand_cnt_reg  <= cand_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        head_reg     <= head_next;
        pos_reg      <= pos_next;
        seek_reg     <= seek_next;
        m_cyl_reg    <= m_cyl_next;
        m_seek_reg   <= m_seek_next;
        m_last_reg   <= m_last_next;
    end

    assign sts.scan_done   = !issuing_reg && !rd_vld_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;
    assign sts.up_pick_end = up_pick_end;
    assign sts.have_cand   = have_cand;
    assign sts.dn_last     = dn_last;

    assign m_valid        = m_valid_reg;
    assign m_cylinder_res = m_cyl_reg;
    assign m_total_seek   = m_seek_reg;
    assign m_last         = m_last_reg;

endmodule

>>> hw/rtl/cscan_disk_scheduler.sv
// C-SCAN disk request scheduler. Send words with s_req_type 0 to load request
// cylinders (up to 32 are kept; adds to a full store and cylinders at or above
// disk_size, clamped to 2..65536, are dropped), then a word with s_req_type 1
// carrying the head cylinder. The block returns the requests above the head in
// ascending order, the end cylinder disk_size-1, cylinder 0, then the requests
// below the head in ascending order; m_last marks the final word, which also
// carries the total seek, and the store is empty afterwards. A new word is
// accepted every cycle while idle. During a run every served cylinder costs
// one sweep through the single read port of the request memory to find the
// next smallest entry. disk_size sits at APB byte address 0.
module cscan_disk_scheduler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [cscan_pkg::CYL_W-1:0]   s_cylinder,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cscan_pkg::CYL_W-1:0]   m_cylinder_res,
    output logic [cscan_pkg::SEEK_W-1:0]  m_total_seek,
    output logic                          m_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cscan_pkg::APB_AW-1:0]  paddr,
    input  logic [cscan_pkg::APB_DW-1:0]  pwdata,
    output logic [cscan_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import cscan_pkg::*;

    logic [SIZE_W-1:0] disk_size_reg, disk_size_next;
    logic              reg_sel;
    cscan_cmd_t        cmd;
    cscan_sts_t        sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1:2] == REG_DISK_SIZE);

    always_comb begin
        disk_size_next = disk_size_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            disk_size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_size_reg <= DISK_SIZE_RST;
        end else begin
            disk_size_reg <= disk_size_next;
        end
    end

    assign prdata = reg_sel ? {{(APB_DW - SIZE_W){1'b0}}, disk_size_reg} : '0;

    cscan_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    cscan_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_cylinder     (s_cylinder),
        .disk_size      (disk_size_reg),
        .cmd            (cmd),
        .sts            (sts),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_cylinder_res (m_cylinder_res),
        .m_total_seek   (m_total_seek),
        .m_last         (m_last)
    );

endmodule

>>> hw/rtl/cscan_chk.sv
module cscan_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_req_type,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [cscan_pkg::CYL_W-1:0]   m_cylinder_res,
    input logic [cscan_pkg::SEEK_W-1:0]  m_total_seek,
    input logic                          m_last
);
    import cscan_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cylinder_res)
                                   && $stable(m_total_seek) && $stable(m_last)))
        else $error("stalled result word changed");

    // seek only on the final word of a run
    a_seek_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_total_seek == '0))
        else $error("nonzero seek on a non-final word");

    // a run blocks new words
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_RUN)) |=> !s_ready)
        else $error("input taken right after a run");

    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind cscan_disk_scheduler cscan_chk u_chk (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import cscan_pkg::*;

    typedef struct packed {
        logic [CYL_W-1:0]  cyl;
        logic [SEEK_W-1:0] seek;
        logic              last;
    } served_t;

    class schedule_board;
        logic [SIZE_W-1:0] disk_size;
        logic [CYL_W-1:0]  requests [MAX_REQUESTS];
        int unsigned       n_requests;
        served_t           served_due [$];
        int unsigned       errors;
        int unsigned       n_stored;
        int unsigned       n_ignored;
        int unsigned       n_runs;
        int unsigned       n_results;

        function new();
            disk_size  = DISK_SIZE_RST;
            n_requests = 0;
            errors     = 0;
            n_stored   = 0;
            n_ignored  = 0;
            n_runs     = 0;
            n_results  = 0;
        endfunction

        function logic [SIZE_W-1:0] eff_size();
            if (disk_size < DISK_SIZE_MIN) return DISK_SIZE_MIN;
            if (disk_size > DISK_SIZE_MAX) return DISK_SIZE_MAX;
            return disk_size;
        endfunction

        function void flag(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endfunction

        function void record_request(logic kind, logic [CYL_W-1:0] cyl);
            int unsigned above [$];
            int unsigned below [$];
            int unsigned sz;
            int unsigned pos;
            int unsigned seek;
            served_t     w;
            sz = int'(eff_size());
            if (kind == REQ_ADD) begin
                if (n_requests < MAX_REQUESTS && int'(cyl) < sz) begin
                    requests[n_requests] = cyl;
                    n_requests++;
                    n_stored++;
                end else begin
                    n_ignored++;
                end
                return;
            end
            n_runs++;
            above = {above, sz - 1};
            below = {below, 32'd0};
            for (int i = 0; i < n_requests; i++) begin
                if (requests[i] > cyl) above = {above, int'(requests[i])};
                else if (requests[i] < cyl) below = {below, int'(requests[i])};
            end
            above.sort();
            below.sort();
            seek = 0;
            pos  = int'(cyl);
            foreach (above[i]) begin
                seek += (above[i] > pos) ? above[i] - pos : pos - above[i];
                pos = above[i];
            end
            seek += sz - 1;
            pos = 0;
            foreach (below[i]) begin
                seek += (below[i] > pos) ? below[i] - pos : pos - below[i];
                pos = below[i];
            end
            foreach (above[i]) begin
                w.cyl  = CYL_W'(above[i]);
                w.seek = '0;
                w.last = 1'b0;
                served_due = {served_due, w};
            end
            foreach (below[i]) begin
                w.cyl  = CYL_W'(below[i]);
                w.last = (i == below.size() - 1);
                w.seek = w.last ? SEEK_W'(seek) : '0;
                served_due = {served_due, w};
            end
            n_requests = 0;
        endfunction

        function void check_served(logic [CYL_W-1:0] cyl, logic [SEEK_W-1:0] seek,
                                   logic last);
            served_t w;
            if (served_due.size() == 0) begin
                flag($sformatf("unexpected word: cylinder %0d seek %0d last %0b",
                               cyl, seek, last));
                return;
            end
            w = served_due.pop_front();
            n_results++;
            if (cyl !== w.cyl)
                flag($sformatf("cylinder_res %0d, expected %0d", cyl, w.cyl));
            if (seek !== w.seek)
                flag($sformatf("total_seek %0d, expected %0d (cylinder %0d)",
                               seek, w.seek, w.cyl));
            if (last !== w.last)
                flag($sformatf("last %0b, expected %0b (cylinder %0d)",
                               last, w.last, w.cyl));
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_req_type;
    logic [CYL_W-1:0]    s_cylinder;
    logic                m_valid;
    logic                m_ready;
    logic [CYL_W-1:0]    m_cylinder_res;
    logic [SEEK_W-1:0]   m_total_seek;
    logic                m_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    schedule_board sb = new();
    int            burst_left   = 0;
    bit            steady_send  = 1'b0;
    bit            hold_off_req = 1'b0;
    int unsigned   n_sizes      = 0;

    cscan_disk_scheduler dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_cylinder     (s_cylinder),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cylinder_res (m_cylinder_res),
        .m_total_seek   (m_total_seek),
        .m_last         (m_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_served(m_cylinder_res, m_total_seek, m_last);
            if (s_valid && s_ready)
                sb.record_request(s_req_type, s_cylinder);
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode;
        int left;
        int hold_left;
        mode      = 0;
        left      = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 400;
            end
            if (left == 0) begin
                mode = int'($urandom_range(0, 3));
                left = int'($urandom_range(20, 200));
            end
            left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic kind, input logic [CYL_W-1:0] cyl);
        int gap;
        if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 12));
            gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_cylinder <= cyl;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // check away from the rising edge so the last accepted word is recorded
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.served_due.size() != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_disk_size(input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DISK_SIZE, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.disk_size = value[SIZE_W-1:0];
        n_sizes++;
    endtask

    function automatic logic [APB_DW-1:0] pick_disk_size();
        logic [SIZE_W-1:0]       sz;
        logic [APB_DW-SIZE_W-1:0] upper;
        case ($urandom_range(0, 9))
            0: sz = 17'd2;
            1: sz = 17'd1;
            2: sz = 17'd3;
            3: sz = DISK_SIZE_MAX;
            4: sz = 17'd65535;
            5: sz = 17'(65537 + $urandom_range(0, 65534));
            6: sz = 17'($urandom_range(2, 64));
            7: sz = 17'($urandom_range(65, 4096));
            default: sz = 17'($urandom_range(2, 65536));
        endcase
        upper = ($urandom_range(0, 2) == 0) ? (APB_DW-SIZE_W)'($urandom) : '0;
        return {upper, sz};
    endfunction

    // adds with random content, then a run from a random head
    task automatic send_batch();
        logic [SIZE_W-1:0] sz;
        logic [CYL_W-1:0]  head;
        logic [CYL_W-1:0]  cyl;
        logic [CYL_W-1:0]  prev;
        int                n;
        int                r;
        sz = sb.eff_size();
        case ($urandom_range(0, 7))
            0: head = CYL_W'($urandom);
            1: head = '0;
            2: head = CYL_W'(sz - 1);
            default: head = CYL_W'($urandom_range(0, int'(sz) - 1));
        endcase
        r = int'($urandom_range(0, 9));
        if (r == 0) n = int'($urandom_range(30, 40));
        else if (r < 3) n = int'($urandom_range(0, 2));
        else n = int'($urandom_range(3, 12));
        prev = CYL_W'($urandom_range(0, int'(sz) - 1));
        repeat (n) begin
            case ($urandom_range(0, 11))
                0: cyl = CYL_W'($urandom);
                1: cyl = '0;
                2: cyl = CYL_W'(sz - 1);
                3: cyl = prev;
                4: cyl = head;
                5: cyl = (sz > 17'd65535) ? CYL_W'($urandom) : CYL_W'(sz);
                default: cyl = CYL_W'($urandom_range(0, int'(sz) - 1));
            endcase
            send_word(REQ_ADD, cyl);
            prev = cyl;
        end
        send_word(REQ_RUN, head);
    endtask

    initial begin
        int          batch;
        int unsigned base;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_req_type = 1'b0;
        s_cylinder = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_disk_size(APB_DW'(DISK_SIZE_RST));
        // empty store
        send_word(REQ_RUN, 16'd0);
        // both ends, duplicates, request equal to head
        send_word(REQ_ADD, 16'd0);
        send_word(REQ_ADD, 16'd65535);
        send_word(REQ_ADD, 16'd65535);
        send_word(REQ_ADD, 16'd32768);
        send_word(REQ_ADD, 16'd5);
        send_word(REQ_RUN, 16'd32768);
        wait_drain();
        // out-of-disk adds, head beyond disk
        write_disk_size(32'd100);
        send_word(REQ_ADD, 16'd99);
        send_word(REQ_ADD, 16'd0);
        send_word(REQ_ADD, 16'd50);
        send_word(REQ_ADD, 16'd150);
        send_word(REQ_ADD, 16'd100);
        send_word(REQ_ADD, 16'd7);
        send_word(REQ_RUN, 16'd65535);
        wait_drain();
        // size below minimum
        write_disk_size(32'd0);
        send_word(REQ_ADD, 16'd1);
        send_word(REQ_ADD, 16'd0);
        send_word(REQ_ADD, 16'd2);
        send_word(REQ_RUN, 16'd1);
        wait_drain();
        // size above maximum, upper bits set
        write_disk_size(32'hFFFF_FFFF);
        send_word(REQ_ADD, 16'd65535);
        send_word(REQ_ADD, 16'd40000);
        send_word(REQ_RUN, 16'd0);

        batch = 0;
        base  = sb.n_stored + sb.n_ignored + sb.n_runs;
        while (sb.n_stored + sb.n_ignored + sb.n_runs - base < 190) begin
            if (batch % 5 == 4) begin
                wait_drain();
                write_disk_size(pick_disk_size());
            end else if ($urandom_range(0, 4) == 0) begin
                wait_drain();
            end
            steady_send = ($urandom_range(0, 3) == 0);
            if (batch == 2)
                hold_off_req = 1'b1;
            send_batch();
            batch++;
        end

        wait_drain();
        repeat (50) @(posedge aclk);
        if (sb.served_due.size() != 0)
            sb.flag($sformatf("%0d expected words never arrived", sb.served_due.size()));
        $display("covered %0d runs, %0d stored and %0d ignored adds, %0d disk sizes",
                 sb.n_runs, sb.n_stored, sb.n_ignored, n_sizes);
        $display("checked %0d served cylinders, %0d mismatches", sb.n_results, sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
